// ===== rtl/lahs_pkg.sv =====
package lahs_pkg;

  localparam int unsigned PIX_W          = 7;
  localparam int unsigned LABEL_W        = 6;
  localparam int unsigned AREA_W         = 22;
  localparam int unsigned MAX_LABELS_DEF = 64;
  localparam int unsigned COUNT_BITS_DEF = 22;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_label;
    logic                    last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [LABEL_W-1:0] segment_label;
    logic [AREA_W-1:0]  segment_area;
    logic               last_result;
    logic               no_segments;
    logic               label_overflow;
  } result_t;

  typedef enum logic [2:0] {
    S_RUN,
    S_DRAIN,
    S_SCAN,
    S_TAIL,
    S_LOAD,
    S_WAIT,
    S_CLEAR
  } state_e;

  typedef struct packed {
    logic pix_en;
    logic scan_clr;
    logic scan_rd;
    logic load;
    logic rank_inc;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic any_label;
    logic scan_end;
    logic res_last;
  } sts_t;

endpackage

// ===== rtl/lahs_ctrl.sv =====
module lahs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  input  logic           out_ready_i,
  input  lahs_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output lahs_pkg::cmd_t cmd_o
);

  lahs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lahs_pkg::S_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lahs_pkg::S_RUN: begin
        if (in_valid_i && in_last_i) begin
          state_d = lahs_pkg::S_DRAIN;
        end
      end
      lahs_pkg::S_DRAIN: begin
        state_d = sts_i.any_label ? lahs_pkg::S_SCAN : lahs_pkg::S_LOAD;
      end
      lahs_pkg::S_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = lahs_pkg::S_TAIL;
        end
      end
      lahs_pkg::S_TAIL: begin
        state_d = lahs_pkg::S_LOAD;
      end
      lahs_pkg::S_LOAD: begin
        state_d = lahs_pkg::S_WAIT;
      end
      lahs_pkg::S_WAIT: begin
        if (out_ready_i) begin
          state_d = sts_i.res_last ? lahs_pkg::S_CLEAR : lahs_pkg::S_SCAN;
        end
      end
      lahs_pkg::S_CLEAR: begin
        state_d = lahs_pkg::S_RUN;
      end
      default: begin
        state_d = lahs_pkg::S_RUN;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      lahs_pkg::S_RUN: begin
        in_ready_o    = 1'b1;
        cmd_o.pix_en  = in_valid_i;
      end
      lahs_pkg::S_DRAIN: begin
        cmd_o.scan_clr = 1'b1;
      end
      lahs_pkg::S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
      end
      lahs_pkg::S_TAIL: begin
      end
      lahs_pkg::S_LOAD: begin
        cmd_o.load = 1'b1;
      end
      lahs_pkg::S_WAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i && !sts_i.res_last) begin
          cmd_o.rank_inc = 1'b1;
          cmd_o.scan_clr = 1'b1;
        end
      end
      lahs_pkg::S_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/lahs_datapath.sv =====
module lahs_datapath #(
  parameter int unsigned MAX_LABELS = lahs_pkg::MAX_LABELS_DEF,
  parameter int unsigned COUNT_BITS = lahs_pkg::COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lahs_pkg::cmd_t    cmd_i,
  input  lahs_pkg::pixel_t  pix_i,
  output lahs_pkg::sts_t    sts_o,
  output lahs_pkg::result_t res_o
);

  localparam int unsigned AW = $clog2(MAX_LABELS);

  logic [COUNT_BITS-1:0] mem [MAX_LABELS];

  logic [lahs_pkg::PIX_W-1:0] lbl_u;
  logic                       lbl_pos;
  logic                       lbl_in_range;
  logic [AW-1:0]              lbl_a;
  logic [AW-1:0]              raddr;

  logic [COUNT_BITS-1:0] rdata_q;
  logic                  vld_r_q;
  logic                  emit_r_q;
  logic [MAX_LABELS-1:0] vld_q;
  logic [MAX_LABELS-1:0] emit_q;

  logic                  b_v_q;
  logic [AW-1:0]         b_addr_q;
  logic                  w_v_q;
  logic [AW-1:0]         w_addr_q;
  logic [COUNT_BITS-1:0] w_data_q;
  logic [COUNT_BITS-1:0] base;
  logic [COUNT_BITS-1:0] wdata;

  logic          any_q;
  logic [AW-1:0] largest_q;
  logic          ovf_q;

  logic [AW-1:0]         scan_addr_q;
  logic                  c_v_q;
  logic [AW-1:0]         c_addr_q;
  logic [AW-1:0]         rank_q;
  logic                  best_found_q;
  logic [COUNT_BITS-1:0] best_cnt_q;
  logic [AW-1:0]         best_addr_q;
  logic [COUNT_BITS-1:0] cnt;
  logic                  take;

  logic [lahs_pkg::AREA_W-1:0] area_sat;
  lahs_pkg::result_t           out_q;

  assign lbl_u        = pix_i.pixel_label;
  assign lbl_pos      = !lbl_u[lahs_pkg::PIX_W-1];
  assign lbl_in_range = lbl_pos && (lbl_u < lahs_pkg::PIX_W'(MAX_LABELS));
  assign lbl_a        = lbl_u[AW-1:0];
  assign raddr        = cmd_i.scan_rd ? scan_addr_q : lbl_a;

  // A write issued in the previous cycle is not yet visible at the read port.
  assign base  = (w_v_q && (w_addr_q == b_addr_q)) ? w_data_q :
                 (vld_r_q ? rdata_q : '0);
  assign wdata = (&base) ? base : base + 1'b1;

  assign cnt  = vld_r_q ? rdata_q : '0;
  assign take = c_v_q && !emit_r_q && (!best_found_q || (cnt > best_cnt_q));

  generate
    if (COUNT_BITS > lahs_pkg::AREA_W) begin : g_clamp
      assign area_sat = (|best_cnt_q[COUNT_BITS-1:lahs_pkg::AREA_W]) ? '1 :
                        best_cnt_q[lahs_pkg::AREA_W-1:0];
    end else begin : g_no_clamp
      assign area_sat = lahs_pkg::AREA_W'(best_cnt_q);
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    rdata_q  <= mem[raddr];
    vld_r_q  <= vld_q[raddr];
    emit_r_q <= emit_q[raddr];
    if (b_v_q) begin
      mem[b_addr_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    b_addr_q <= lbl_a;
    w_addr_q <= b_addr_q;
    w_data_q <= wdata;
    c_addr_q <= scan_addr_q;
    if (take) begin
      best_cnt_q  <= cnt;
      best_addr_q <= c_addr_q;
    end
    if (cmd_i.load) begin
      out_q.segment_label  <= any_q ? lahs_pkg::LABEL_W'(best_addr_q) : '0;
      out_q.segment_area   <= any_q ? area_sat : '0;
      out_q.last_result    <= !any_q || (rank_q == largest_q);
      out_q.no_segments    <= !any_q;
      out_q.label_overflow <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q        <= 1'b0;
      w_v_q        <= 1'b0;
      vld_q        <= '0;
      emit_q       <= '0;
      any_q        <= 1'b0;
      largest_q    <= '0;
      ovf_q        <= 1'b0;
      scan_addr_q  <= '0;
      c_v_q        <= 1'b0;
      rank_q       <= '0;
      best_found_q <= 1'b0;
    end else begin
      b_v_q <= cmd_i.pix_en && lbl_in_range;
      w_v_q <= b_v_q;
      c_v_q <= cmd_i.scan_rd;
      if (b_v_q) begin
        vld_q[b_addr_q] <= 1'b1;
      end
      if (cmd_i.pix_en && lbl_in_range) begin
        any_q <= 1'b1;
        if (!any_q || (lbl_a > largest_q)) begin
          largest_q <= lbl_a;
        end
      end
      if (cmd_i.pix_en && lbl_pos && !lbl_in_range) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.scan_clr) begin
        scan_addr_q  <= '0;
        best_found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          scan_addr_q <= scan_addr_q + AW'(1);
        end
        if (take) begin
          best_found_q <= 1'b1;
        end
      end
      if (cmd_i.load && any_q) begin
        emit_q[best_addr_q] <= 1'b1;
      end
      if (cmd_i.rank_inc) begin
        rank_q <= rank_q + AW'(1);
      end
      if (cmd_i.clear) begin
        vld_q  <= '0;
        emit_q <= '0;
        any_q  <= 1'b0;
        ovf_q  <= 1'b0;
        rank_q <= '0;
      end
    end
  end

  assign sts_o.any_label = any_q;
  assign sts_o.scan_end  = (scan_addr_q == largest_q);
  assign sts_o.res_last  = out_q.last_result;
  assign res_o           = out_q;

endmodule

// ===== rtl/label_area_histogram_sort.sv =====
// Counts pixels per segment label over a label map, one pixel per cycle, and on
// the pixel marked last emits one transaction per label from 0 to the largest
// label seen, ordered by descending area with ties in ascending label order.
// Negative labels are skipped; labels at or above MAX_LABELS are dropped and
// reported through label_overflow on every result of the run. A map without
// any counted pixel yields a single result with no_segments set. Pixels are
// taken at one per cycle. After the last pixel, a drain step precedes ranking
// and a clear step follows the final result; each ranked result is found by
// one scan of labels 0 to the largest label seen and then waits for the
// consumer. The counts live in a memory with one read port and one write
// port that is scanned once per ranked result. Input is not accepted while a
// run is being ranked or emitted. The counts are cleared through per-label
// valid flags, so no clearing pass follows reset or a run.
module label_area_histogram_sort #(
  parameter int unsigned MAX_LABELS = lahs_pkg::MAX_LABELS_DEF,
  parameter int unsigned COUNT_BITS = lahs_pkg::COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lahs_pkg::pixel_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lahs_pkg::result_t out_data_o
);

  lahs_pkg::cmd_t cmd;
  lahs_pkg::sts_t sts;

  lahs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_pixel),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .cmd_o      (cmd)
  );

  lahs_datapath #(
    .MAX_LABELS(MAX_LABELS),
    .COUNT_BITS(COUNT_BITS)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .pix_i (in_data_i),
    .sts_o (sts),
    .res_o (out_data_o)
  );

endmodule

// ===== rtl/lahs_checker.sv =====
module lahs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input lahs_pkg::pixel_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input lahs_pkg::result_t out_data_o
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_segments |->
      out_data_o.last_result && (out_data_o.segment_area == '0))
    else $error("empty-map result is malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("pixels accepted while a result is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_pixel |=> !in_ready_o && !out_valid_o)
    else $error("no ranking phase after the last pixel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last_result |=> !out_valid_o && !in_ready_o)
    else $error("run did not close after its final result");

endmodule

bind label_area_histogram_sort lahs_checker u_lahs_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import lahs_pkg::*;

  localparam int NUM_LABELS  = MAX_LABELS_DEF;
  localparam longint CNT_MAX = (longint'(1) << COUNT_BITS_DEF) - 1;
  localparam longint AREA_MAX = (longint'(1) << AREA_W) - 1;
  localparam int RANDOM_ITEMS = 390;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 10000000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  pixel_t  in_data = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  result_t out_data;

  pixel_t  pixel_q[$];
  result_t ranked_q[$];

  longint  hist_cnt[NUM_LABELS];
  int      top_label = -1;
  bit      drop_seen = 1'b0;

  int      phase = 0;
  int      accepted_cnt = 0;
  int      error_cnt = 0;
  int      hold_left = 0;
  bit      pressure_done = 1'b0;
  longint  cycle_cnt = 0;

  label_area_histogram_sort dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report(string what, longint got, longint want);
    $display("tb: mismatch on %s at cycle %0d: got %0d, expected %0d",
             what, cycle_cnt, got, want);
    error_cnt++;
  endtask

  task automatic push_pixel(int lbl, bit last);
    pixel_t p;
    p.pixel_label = 7'(lbl);
    p.last_pixel  = last;
    pixel_q.push_back(p);
  endtask

  // Counts one pixel and, on the last pixel of a map, appends the ranked results.
  task automatic tally_pixel(pixel_t px);
    int      lbl;
    int      n;
    int      j;
    int      cur;
    int      order[NUM_LABELS];
    longint  a;
    result_t r;
    lbl = $signed(px.pixel_label);
    if (lbl >= 0) begin
      if (lbl >= NUM_LABELS) begin
        drop_seen = 1'b1;
      end else begin
        if (hist_cnt[lbl] < CNT_MAX) hist_cnt[lbl]++;
        if (lbl > top_label) top_label = lbl;
      end
    end
    if (!px.last_pixel) return;
    if (top_label < 0) begin
      r = '0;
      r.last_result    = 1'b1;
      r.no_segments    = 1'b1;
      r.label_overflow = drop_seen;
      ranked_q.push_back(r);
    end else begin
      n = top_label + 1;
      for (int i = 0; i < n; i++) begin
        cur = i;
        j = i;
        while (j > 0 && hist_cnt[order[j-1]] < hist_cnt[cur]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = cur;
      end
      for (int i = 0; i < n; i++) begin
        a = hist_cnt[order[i]];
        if (a > AREA_MAX) a = AREA_MAX;
        r.segment_label  = LABEL_W'(order[i]);
        r.segment_area   = AREA_W'(a);
        r.last_result    = (i == n - 1);
        r.no_segments    = 1'b0;
        r.label_overflow = drop_seen;
        ranked_q.push_back(r);
      end
    end
    foreach (hist_cnt[k]) hist_cnt[k] = 0;
    top_label = -1;
    drop_seen = 1'b0;
  endtask

  always @(posedge clk_i) begin
    bit took;
    int tx_idle;
    tx_idle = (phase == 0) ? 23 : (phase == 1) ? 62 : 0;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        tally_pixel(in_data);
        void'(pixel_q.pop_front());
        accepted_cnt++;
      end
      if (in_valid && !took) begin
        in_valid <= 1'b1;
      end else if (pixel_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
        in_valid <= 1'b1;
        in_data  <= pixel_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    int      rx_idle;
    rx_idle = (phase == 0) ? 62 : (phase == 1) ? 23 : 0;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (ranked_q.size() == 0) begin
          report("result transaction", 1, 0);
        end else begin
          want = ranked_q.pop_front();
          if (out_data.segment_label != want.segment_label)
            report("segment_label", out_data.segment_label, want.segment_label);
          if (out_data.segment_area != want.segment_area)
            report("segment_area", out_data.segment_area, want.segment_area);
          if (out_data.last_result != want.last_result)
            report("last_result", out_data.last_result, want.last_result);
          if (out_data.no_segments != want.no_segments)
            report("no_segments", out_data.no_segments, want.no_segments);
          if (out_data.label_overflow != want.label_overflow)
            report("label_overflow", out_data.label_overflow, want.label_overflow);
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (phase == 2 && !pressure_done && out_valid && pixel_q.size() > 0) begin
        hold_left     <= HOLD_CYCLES;
        pressure_done <= 1'b1;
        out_ready     <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    int total;
    int kind;
    int span;
    int len;
    int neg_pct;
    int lbl;
    foreach (hist_cnt[k]) hist_cnt[k] = 0;

    // Directed maps: single pixel, empty maps, widest map, ties, skipped labels.
    push_pixel(0, 1'b1);
    push_pixel(-1, 1'b1);
    push_pixel(-64, 1'b1);
    push_pixel(63, 1'b1);
    push_pixel(5, 1'b0);
    push_pixel(3, 1'b0);
    push_pixel(5, 1'b0);
    push_pixel(3, 1'b0);
    push_pixel(1, 1'b1);
    push_pixel(2, 1'b0);
    push_pixel(-1, 1'b0);
    push_pixel(2, 1'b0);
    push_pixel(-5, 1'b0);
    push_pixel(0, 1'b1);
    push_pixel(1, 1'b0);
    push_pixel(1, 1'b0);
    push_pixel(-1, 1'b1);

    total = pixel_q.size() + RANDOM_ITEMS;
    while (pixel_q.size() < total) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        span = 0;
        len = $urandom_range(5, 1);
        neg_pct = 100;
      end else if (kind == 1) begin
        span = 63;
        len = $urandom_range(60, 20);
        neg_pct = 10;
      end else begin
        span = $urandom_range(15);
        len = $urandom_range(16, 1);
        neg_pct = 15;
      end
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(99) < neg_pct) lbl = -int'($urandom_range(64, 1));
        else lbl = int'($urandom_range(span));
        push_pixel(lbl, k == len - 1);
      end
    end
    total = pixel_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt < total / 3) @(posedge clk_i);
    phase <= 1;
    while (accepted_cnt < 2 * total / 3) @(posedge clk_i);
    phase <= 2;
    while (pixel_q.size() != 0 || ranked_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_cnt == 0 && ranked_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
